@@ rtl/core/rbbp_pkg.sv @@
// Package for the residual bucket bit packer.
// Holds the field widths, register indexes and shared types; no dependencies.
`default_nettype none

package rbbp_pkg;

	// Widest bucket code, in bits, that the packer supports.
	localparam int unsigned MAX_BITS = 2;

	// Field widths.
	localparam int unsigned RESIDUAL_W = 16;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned FILL_W     = 3;
	localparam int unsigned BPV_W      = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BITS_PER_VALUE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_0       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_1       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_2       = 2'd3;

	// Reset value of the bits-per-value register.
	localparam logic [BPV_W-1:0] BPV_RESET = 2'd1;

	typedef logic signed [RESIDUAL_W-1:0] resid_t;
	typedef logic [MAX_BITS-1:0]          bucket_t;

	// Cutoffs as seen by the bucket comparator.
	typedef struct packed {
		resid_t cutoff_2;
		resid_t cutoff_1;
		resid_t cutoff_0;
		logic   two_bits;
	} rbbp_cut_t;

endpackage : rbbp_pkg

`default_nettype wire

@@ rtl/core/residual_bucket_bit_packer.sv @@
// Top level of the residual bucket bit packer: input stage, bit packing and output register.
// Depends on rbbp_pkg and rbbp_bucket.
`default_nettype none

// Quantizes each signed 16-bit residual (12 fraction bits) into a 1- or 2-bit
// bucket against the configured cutoffs and packs the bucket bits, least
// significant first, into bytes whose first bit sits in bit 7. A byte leaves
// on the master side when it fills up or when the input beat carries tlast,
// in which case the partial byte is zero padded and marked with tlast. The
// block takes one input beat per cycle while the output register is not
// stalled. A beat is registered in the input stage, then quantized and
// packed into the output register once that register is free. The output
// register holds a byte while the master side stalls, and the input stage
// keeps accepting while it is empty or can hand its beat on, which needs the
// output register free or draining. Configuration writes are applied at once
// and must only be issued while the block is idle.
module residual_bucket_bit_packer (
	input  wire                              clk,
	input  wire                              arst_n,
	// Slave side: tdata[15:0] = residual; tlast = vector_end.
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [rbbp_pkg::RESIDUAL_W-1:0]  s_tdata,
	input  wire                              s_tlast,
	// Master side: tdata[7:0] = packed_byte; tlast = last_of_vector.
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [rbbp_pkg::BYTE_W-1:0]      m_tdata,
	output logic                             m_tlast,
	// Configuration write port.
	input  wire                              cfg_we,
	input  wire  [rbbp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [rbbp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import rbbp_pkg::*;

	// Configuration registers.
	logic [BPV_W-1:0] bits_per_value_q;
	resid_t           cutoff_0_q;
	resid_t           cutoff_1_q;
	resid_t           cutoff_2_q;

	// Input stage.
	logic   valid_s1;
	resid_t residual_s1;
	logic   vend_s1;

	// Packing state.
	logic [BYTE_W-1:0] partial_q;
	logic [FILL_W-1:0] fill_q;

	// Output register.
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              out_free;
	logic              fire_s1;
	rbbp_cut_t         cut;
	bucket_t           bucket;
	logic [BYTE_W-1:0] mask_0;
	logic [BYTE_W-1:0] mask_1;
	logic [BYTE_W-1:0] acc;
	logic              full;
	logic              emit;
	logic [FILL_W-1:0] fill_next;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_per_value_q <= BPV_RESET;
			cutoff_0_q       <= '0;
			cutoff_1_q       <= '0;
			cutoff_2_q       <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BITS_PER_VALUE: bits_per_value_q <= cfg_wdata[BPV_W-1:0];
				REG_CUTOFF_0:       cutoff_0_q       <= resid_t'(cfg_wdata);
				REG_CUTOFF_1:       cutoff_1_q       <= resid_t'(cfg_wdata);
				REG_CUTOFF_2:       cutoff_2_q       <= resid_t'(cfg_wdata);
				default:            ;
			endcase
		end
	end

	// Zero and one select one bit per value; larger codes saturate to MAX_BITS.
	assign cut.two_bits = (MAX_BITS >= 2) && (bits_per_value_q >= BPV_W'(2));
	assign cut.cutoff_0 = cutoff_0_q;
	assign cut.cutoff_1 = cutoff_1_q;
	assign cut.cutoff_2 = cutoff_2_q;

	// Handshake: the stage-one beat moves on whenever the output register can take a result.
	assign out_free = !out_valid_q || m_tready;
	assign fire_s1  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || fire_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			residual_s1 <= resid_t'(s_tdata);
			vend_s1     <= s_tlast;
		end
	end

	rbbp_bucket u_bucket (
		.residual (residual_s1),
		.cut      (cut),
		.bucket   (bucket)
	);

	// Bit insertion: bucket bit 0 lands at position 7 - fill, bit 1 just below it.
	// A byte that fills on the first bit drops the second bit.
	always_comb begin
		mask_0    = BYTE_W'(8'h80) >> fill_q;
		mask_1    = BYTE_W'(8'h40) >> fill_q;
		acc       = partial_q | (bucket[0] ? mask_0 : '0);
		full      = (fill_q == FILL_W'(7));
		fill_next = fill_q + FILL_W'(1);
		if (cut.two_bits) begin
			if (fill_q != FILL_W'(7)) begin
				acc = acc | (bucket[MAX_BITS-1] ? mask_1 : '0);
			end
			full      = full || (fill_q == FILL_W'(6));
			fill_next = fill_q + FILL_W'(2);
		end
		emit = full || vend_s1;
	end

	// Packing state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			fill_q    <= '0;
		end else if (fire_s1) begin
			if (emit) begin
				partial_q <= '0;
				fill_q    <= '0;
			end else begin
				partial_q <= acc;
				fill_q    <= fill_next;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			out_byte_q <= acc;
			out_last_q <= vend_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;

endmodule : residual_bucket_bit_packer

`default_nettype wire

@@ rtl/core/rbbp_bucket.sv @@
// Bucket comparator: maps one residual to its bucket index.
// Depends on rbbp_pkg for the residual and cutoff types.
`default_nettype none

module rbbp_bucket (
	input  rbbp_pkg::resid_t    residual,
	input  rbbp_pkg::rbbp_cut_t cut,
	output rbbp_pkg::bucket_t   bucket
);
	import rbbp_pkg::*;

	logic below_0;
	logic below_1;
	logic below_2;

	// Three signed compares run in parallel; the first hit in index order wins.
	assign below_0 = residual < cut.cutoff_0;
	assign below_1 = residual < cut.cutoff_1;
	assign below_2 = residual < cut.cutoff_2;

	always_comb begin
		if (!cut.two_bits) begin
			bucket = below_0 ? bucket_t'(0) : bucket_t'(1);
		end else if (below_0) begin
			bucket = bucket_t'(0);
		end else if (below_1) begin
			bucket = bucket_t'(1);
		end else if (below_2) begin
			bucket = bucket_t'(2);
		end else begin
			bucket = bucket_t'(3);
		end
	end

endmodule : rbbp_bucket

`default_nettype wire
